// File: hw/rtl/bounded_request_queue_top_defines.svh
// Assertion macros for the bounded request queue.
`ifndef BOUNDED_REQUEST_QUEUE_TOP_DEFINES_SVH
`define BOUNDED_REQUEST_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brq assertion failed");

// Next-cycle implication, checked outside reset.
`define BRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brq assertion failed");

`endif

// File: hw/rtl/brq_pkg.sv
// Package: sizes, codes and control types of the bounded request queue.
`default_nettype none
package brq_pkg;

	localparam int DEPTH       = 32;
	localparam int VALUE_BITS  = 16;
	localparam int STAMP_BITS  = 32;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int LIM_W       = 6;
	localparam int LIMIT_RESET = 32;
	localparam int KIND_W      = 2;

	localparam int IN_BITS     = VALUE_BITS + STAMP_BITS + IDX_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH   = 2'd0,
		K_POP    = 2'd1,
		K_REMOVE = 2'd2,
		K_FIND   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		S_OK   = 2'd0,
		S_FULL = 2'd1,
		S_BAD  = 2'd2,
		S_MISS = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request on input transfer
		logic step;    // advance find scan
		logic finish;  // commit op, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_find;
		logic scan_end;
	} sts_t;

	// result item, status in the lowest bits
	typedef struct packed {
		logic [STAMP_BITS-1:0] head_stamp;
		logic                  is_empty;
		logic                  is_full;
		logic [CNT_W-1:0]      occupancy;
		logic [STAMP_BITS-1:0] out_stamp;
		logic [IDX_W-1:0]      out_position;
		logic [VALUE_BITS-1:0] out_value;
		status_t               status;
	} res_t;

	localparam int OUT_BITS    = $bits(res_t);
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage
`default_nettype wire

// File: hw/rtl/brq_ctrl.sv
// Controller: request sequencing and result-valid tracking.
`default_nettype none
module brq_ctrl import brq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// request registers are free whenever idle
				in_ready = 1'b1;
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_find && !sts.scan_end) begin
					cmd.step = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					// commit only once the result register is free
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: hw/rtl/brq_datapath.sv
// Datapath: compacting entry array, request and limit registers, result register.
`default_nettype none
module brq_datapath import brq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [LIM_W-1:0]      cfg_data,
	input  kind_t                 in_kind,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic [STAMP_BITS-1:0] in_stamp,
	input  logic [IDX_W-1:0]      in_pos,
	output res_t                  res
);

	kind_t                 kind_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      count_q;
	logic [LIM_W-1:0]      lim_q;
	logic [VALUE_BITS-1:0] ent_val_q  [DEPTH];
	logic [STAMP_BITS-1:0] ent_time_q [DEPTH];
	res_t                  res_q;

	logic [VALUE_BITS-1:0] val_nxt  [DEPTH];
	logic [STAMP_BITS-1:0] time_nxt [DEPTH];
	logic [CNT_W-1:0]      cnt_nxt;
	logic [CNT_W-1:0]      eff_lim;
	logic [VALUE_BITS-1:0] rd_val;
	logic [STAMP_BITS-1:0] rd_time;
	logic                  in_range;
	logic                  hit;
	res_t                  res_d;

	always_comb begin
		if (32'(lim_q) > DEPTH) begin
			eff_lim = CNT_W'(DEPTH);
		end else begin
			eff_lim = CNT_W'(lim_q);
		end
	end

	assign rd_val   = ent_val_q[idx_q];
	assign rd_time  = ent_time_q[idx_q];
	assign in_range = CNT_W'(idx_q) < count_q;
	assign hit      = in_range && (rd_val == val_q);

	assign sts.is_find  = (kind_q == K_FIND);
	assign sts.scan_end = hit || ((CNT_W'(idx_q) + CNT_W'(1)) >= count_q);

	always_comb begin
		val_nxt  = ent_val_q;
		time_nxt = ent_time_q;
		cnt_nxt  = count_q;
		res_d    = '0;
		res_d.status = S_OK;
		unique case (kind_q)
			K_PUSH: begin
				if (count_q >= eff_lim) begin
					res_d.status = S_FULL;
				end else begin
					val_nxt[count_q[IDX_W-1:0]]  = val_q;
					time_nxt[count_q[IDX_W-1:0]] = stamp_q;
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			K_POP, K_REMOVE: begin
				if (!in_range) begin
					res_d.status = S_BAD;
				end else begin
					res_d.out_value    = rd_val;
					res_d.out_stamp    = rd_time;
					res_d.out_position = idx_q;
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (IDX_W'(i) >= idx_q) begin
							val_nxt[i]  = ent_val_q[i + 1];
							time_nxt[i] = ent_time_q[i + 1];
						end
					end
					cnt_nxt = count_q - CNT_W'(1);
				end
			end
			K_FIND: begin
				if (hit) begin
					res_d.out_value    = rd_val;
					res_d.out_stamp    = rd_time;
					res_d.out_position = idx_q;
				end else begin
					res_d.status = S_MISS;
				end
			end
		endcase
		res_d.occupancy  = cnt_nxt;
		res_d.is_full    = cnt_nxt >= eff_lim;
		res_d.is_empty   = (cnt_nxt == '0);
		res_d.head_stamp = (cnt_nxt == '0) ? '0 : time_nxt[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lim_q   <= LIM_W'(LIMIT_RESET);
		end else begin
			if (cfg_we) begin
				lim_q <= cfg_data;
			end
			if (cmd.finish) begin
				count_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			val_q   <= in_value;
			stamp_q <= in_stamp;
			idx_q   <= (in_kind == K_REMOVE) ? in_pos : '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.finish) begin
			ent_val_q  <= val_nxt;
			ent_time_q <= time_nxt;
			res_q      <= res_d;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

// File: hw/rtl/bounded_request_queue_top.sv
// Top level of the bounded request queue: stream ports, controller and datapath.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------------------
//  s_*      | in        | s_tvalid / s_tready          | tuser: kind; tdata: value,stamp,pos
//  m_*      | out       | m_tvalid / m_tready          | tdata: result fields
//  cfg_*    | in        | cfg_we (no wait)             | cfg_data: capacity limit
//
// Push, pop and remove are captured on input transfer, then committed on the
// shift-compacting entry array once the result register is free.
// Find scans one entry per cycle through the single array read port, stopping at the
// first match or at the last occupied entry.
// One request is in flight at a time; the next input transfer is taken as soon as
// the controller is idle, so a waiting result does not block that transfer.
// Reset clears occupancy and restores the limit to 32; entry contents are not cleared.
// A stall on m_tready holds the result and delays the commit of the following
// request, which keeps the input closed until the result register frees up.
`default_nettype none
`include "bounded_request_queue_top_defines.svh"
module bounded_request_queue_top import brq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [15:0] req_value, [47:16] arrival_stamp, [52:48] position, rest zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] kind
	input  logic [KIND_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] status, [17:2] out_value, [22:18] out_position, [54:23] out_stamp,
	// [60:55] occupancy, [61] is_full, [62] is_empty, [94:63] head_stamp, rest zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [LIM_W-1:0]       cfg_data
);

	cmd_t cmd;
	sts_t sts;
	res_t res;

	brq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_kind  (kind_t'(s_tuser)),
		.in_value (s_tdata[VALUE_BITS-1:0]),
		.in_stamp (s_tdata[VALUE_BITS +: STAMP_BITS]),
		.in_pos   (s_tdata[VALUE_BITS + STAMP_BITS +: IDX_W]),
		.res      (res)
	);

	// result struct packs status lowest; pad to whole bytes
	assign m_tdata = OUT_TDATA_W'(res);

	// the request under work keeps the input closed until it commits
	`BRQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a fresh result never lands on one that is still waiting
	`BRQ_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.finish, !m_tvalid || m_tready)
	// occupancy stays within the array
	`BRQ_ASSERT_NOW(a_occ_bound, clk, arst_n, m_tvalid, 32'(res.occupancy) <= DEPTH)
	// empty result reports a zero head stamp
	`BRQ_ASSERT_NOW(a_empty_head, clk, arst_n, m_tvalid && res.is_empty,
		res.head_stamp == '0 && res.occupancy == '0)

endmodule
`default_nettype wire

// File: sim/bounded_request_queue_top_test.sv
// Self-checking testbench for the bounded request queue: random stream traffic with a predictor.
`timescale 1ns / 1ps
module bounded_request_queue_top_test;
	import brq_pkg::*;

	// One request as the sender offers it.
	typedef struct {
		kind_t                 kind;
		logic [VALUE_BITS-1:0] value;
		logic [STAMP_BITS-1:0] stamp;
		logic [IDX_W-1:0]      pos;
	} request_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [KIND_W-1:0]      s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [LIM_W-1:0]       cfg_data = '0;

	bounded_request_queue_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Shadow of the queue contents and the capacity register.
	logic [VALUE_BITS-1:0] held_value[$];
	logic [STAMP_BITS-1:0] held_stamp[$];
	logic [LIM_W-1:0]      cap_limit = LIM_W'(LIMIT_RESET);

	request_t request_backlog[$];  // filled by the stimulus, drained by the driver
	res_t     awaited_replies[$];  // predicted results, oldest first

	int  n_sent = 0;
	int  n_accepted = 0;
	int  n_results = 0;
	int  n_cfg_writes = 0;
	int  err_count = 0;
	int  status_seen[4] = '{0, 0, 0, 0};
	bit  in_taken = 1'b0;   // input transfer at the last rising edge
	bit  hold_req = 1'b0;   // asks the receiver for a long hold-off
	int  burst_left = 1;
	int  gap_left = 0;
	int  hold_left = 0;
	int  pat_cycle = 0;

	logic [VALUE_BITS-1:0] value_pool[8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
		16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one request to the shadow queue and returns the result it should give.
	function automatic res_t apply_request(kind_t k, logic [VALUE_BITS-1:0] v,
			logic [STAMP_BITS-1:0] s, logic [IDX_W-1:0] p);
		res_t r;
		int   lim;
		int   at;
		int   hit;
		lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
		r = '0;
		r.status = S_OK;
		case (k)
			K_PUSH: begin
				if (held_value.size() >= lim) begin
					r.status = S_FULL;
				end else begin
					held_value.push_back(v);
					held_stamp.push_back(s);
				end
			end
			K_POP, K_REMOVE: begin
				at = (k == K_POP) ? 0 : p;
				if (at >= held_value.size()) begin
					r.status = S_BAD;
				end else begin
					r.out_value = held_value[at];
					r.out_stamp = held_stamp[at];
					r.out_position = IDX_W'(at);
					held_value.delete(at);
					held_stamp.delete(at);
				end
			end
			default: begin
				hit = -1;
				for (int i = 0; i < held_value.size(); i++) begin
					if (hit < 0 && held_value[i] == v)
						hit = i;
				end
				if (hit < 0) begin
					r.status = S_MISS;
				end else begin
					r.out_value = held_value[hit];
					r.out_stamp = held_stamp[hit];
					r.out_position = IDX_W'(hit);
				end
			end
		endcase
		r.occupancy = CNT_W'(held_value.size());
		r.is_full = held_value.size() >= lim;
		r.is_empty = held_value.size() == 0;
		r.head_stamp = (held_value.size() == 0) ? '0 : held_stamp[0];
		return r;
	endfunction

	task automatic compare_field(string name, logic [STAMP_BITS-1:0] want,
			logic [STAMP_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// Monitor: outputs sampled at the rising edge. The result transfer is handled
	// before the input transfer; a result never belongs to a request taken in the
	// same cycle.
	always @(posedge clk) begin : watch_ports
		res_t got;
		res_t want;
		in_taken = arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_BITS-1:0];
				if (awaited_replies.size() == 0) begin
					$error("result transfer with nothing outstanding: %0h", m_tdata);
					err_count++;
				end else begin
					want = awaited_replies.pop_front();
					compare_field("status", want.status, got.status);
					compare_field("out_value", want.out_value, got.out_value);
					compare_field("out_position", want.out_position, got.out_position);
					compare_field("out_stamp", want.out_stamp, got.out_stamp);
					compare_field("occupancy", want.occupancy, got.occupancy);
					compare_field("is_full", want.is_full, got.is_full);
					compare_field("is_empty", want.is_empty, got.is_empty);
					compare_field("head_stamp", want.head_stamp, got.head_stamp);
					status_seen[want.status]++;
					n_results++;
				end
			end
			if (in_taken) begin
				awaited_replies.push_back(apply_request(kind_t'(s_tuser),
					s_tdata[VALUE_BITS-1:0],
					s_tdata[VALUE_BITS +: STAMP_BITS],
					s_tdata[VALUE_BITS + STAMP_BITS +: IDX_W]));
				n_accepted++;
			end
			if (cfg_we) begin
				cap_limit = cfg_data;
				n_cfg_writes++;
			end
		end
	end

	// Driver: offers requests in bursts with random gaps; holds an offer until taken.
	always @(negedge clk) begin : drive_requests
		request_t it;
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				// offer still pending, keep it steady
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_backlog.size() != 0) begin
				it = request_backlog.pop_front();
				s_tdata <= IN_TDATA_W'({it.pos, it.stamp, it.value});
				s_tuser <= it.kind;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: rotates through always-ready, mostly-ready, mostly-stalled and
	// periodic patterns; a hold-off request overrides all of them.
	always @(negedge clk) begin : drive_ready
		bit ready;
		pat_cycle++;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 200;
		end
		if (hold_left != 0) begin
			hold_left--;
			ready = 1'b0;
		end else begin
			case ((pat_cycle / 96) % 4)
				0: ready = 1'b1;
				1: ready = $urandom_range(0, 9) < 7;
				2: ready = $urandom_range(0, 3) == 0;
				default: ready = (pat_cycle % 5) != 0;
			endcase
		end
		m_tready <= ready;
	end

	task automatic add_request(kind_t k, logic [VALUE_BITS-1:0] v,
			logic [STAMP_BITS-1:0] s, logic [IDX_W-1:0] p);
		request_t it;
		it.kind = k;
		it.value = v;
		it.stamp = s;
		it.pos = p;
		request_backlog.push_back(it);
		n_sent++;
	endtask

	// Random request; values mostly from a small pool so finds hit and repeat.
	task automatic add_random(int push_pct);
		kind_t                 k;
		logic [VALUE_BITS-1:0] v;
		logic [IDX_W-1:0]      p;
		int                    pick;
		pick = $urandom_range(0, 99);
		if (pick < push_pct)
			k = K_PUSH;
		else
			k = kind_t'($urandom_range(1, 3));
		if ($urandom_range(0, 9) < 7)
			v = value_pool[$urandom_range(0, 7)];
		else
			v = VALUE_BITS'($urandom_range(0, 65535));
		if ($urandom_range(0, 9) < 7)
			p = IDX_W'($urandom_range(0, 7));
		else
			p = IDX_W'($urandom_range(0, 31));
		add_request(k, v, $urandom, p);
	endtask

	// Waits until every request sent so far has produced its result.
	task automatic drain();
		while (n_results != n_sent)
			@(negedge clk);
	endtask

	task automatic write_limit(logic [LIM_W-1:0] lim);
		drain();
		@(negedge clk);
		cfg_data = lim;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin : stimulus
		int limits[12];
		limits = '{63, 32, 1, 8, 0, 20, 3, 32, 63, 2, 31, 12};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty queue: pop, remove and find all fail.
		add_request(K_POP, 16'h0000, 32'h0, 5'd0);
		add_request(K_REMOVE, 16'h0000, 32'h0, 5'd0);
		add_request(K_FIND, 16'h0000, 32'h0, 5'd0);
		// Field extremes, duplicate value for first-match search.
		add_request(K_PUSH, 16'h0000, 32'h0000_0000, 5'd31);
		add_request(K_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
		add_request(K_PUSH, 16'h1234, 32'h0000_0100, 5'd0);
		add_request(K_PUSH, 16'hFFFF, 32'h1234_5678, 5'd0);
		add_request(K_FIND, 16'hFFFF, 32'h0, 5'd0);
		add_request(K_FIND, 16'hAAAA, 32'h0, 5'd0);
		// Index past the end and exactly at occupancy, then tail and middle removal.
		add_request(K_REMOVE, 16'h0, 32'h0, 5'd31);
		add_request(K_REMOVE, 16'h0, 32'h0, 5'd4);
		add_request(K_REMOVE, 16'h0, 32'h0, 5'd3);
		add_request(K_REMOVE, 16'h0, 32'h0, 5'd1);
		add_request(K_FIND, 16'h1234, 32'h0, 5'd0);
		add_request(K_POP, 16'h0, 32'h0, 5'd0);
		add_request(K_POP, 16'h0, 32'h0, 5'd0);
		add_request(K_POP, 16'h0, 32'h0, 5'd0);
		// Limit of zero: push rejected, full and empty together.
		write_limit(6'd0);
		add_request(K_PUSH, 16'h5555, 32'hDEAD_BEEF, 5'd0);
		add_request(K_FIND, 16'h5555, 32'h0, 5'd0);
		// Limit of two: third push rejected.
		write_limit(6'd2);
		add_request(K_PUSH, 16'h0001, 32'h0000_0001, 5'd0);
		add_request(K_PUSH, 16'h0002, 32'h0000_0002, 5'd0);
		add_request(K_PUSH, 16'h0003, 32'h0000_0003, 5'd0);
		// Limit dropped below occupancy: entries stay, full until below the limit.
		write_limit(6'd1);
		add_request(K_PUSH, 16'h0004, 32'h0000_0004, 5'd0);
		add_request(K_POP, 16'h0, 32'h0, 5'd0);
		add_request(K_POP, 16'h0, 32'h0, 5'd0);

		// Random phases; entries carry over from one limit setting to the next.
		foreach (limits[i]) begin
			write_limit(LIM_W'(limits[i]));
			if (i == 0)
				hold_req = 1'b1;   // receiver stalls long while the sender keeps offering
			for (int n = 0; n < 54; n++)
				add_random((i % 2 == 0) ? 75 : 45);
		end

		drain();
		repeat (50) @(negedge clk);
		if (awaited_replies.size() != 0) begin
			$error("%0d results never arrived", awaited_replies.size());
			err_count++;
		end
		$display("Ran %0d requests through %0d capacity writes (limits 0 to 63).",
			n_accepted, n_cfg_writes);
		$display("Results: %0d ok, %0d rejected full, %0d empty or bad index, %0d not found.",
			status_seen[S_OK], status_seen[S_FULL], status_seen[S_BAD], status_seen[S_MISS]);
		if (err_count == 0)
			$display("[bounded_request_queue_top] OK");
		else
			$display("[bounded_request_queue_top] ERROR");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("[bounded_request_queue_top] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/brq_pkg.sv
hw/rtl/brq_ctrl.sv
hw/rtl/brq_datapath.sv
hw/rtl/bounded_request_queue_top.sv
sim/bounded_request_queue_top_test.sv
